// ===== sv/dcbg_pkg.sv =====
// ----------------------------------------------------------------------------
// dcbg_pkg
// Shared types, address map and helpers for the dual CPU board glue.
// ----------------------------------------------------------------------------
package dcbg_pkg;

  localparam int unsigned BG_STORE_DEPTH_DEF = 2048;

  // request kinds carried on the input tuser
  typedef enum logic [2:0] {
    REQ_WRITE       = 3'd0,
    REQ_READ        = 3'd1,
    REQ_FRAME_START = 3'd2,
    REQ_VBLANK_END  = 3'd3,
    REQ_TIMER_TICK  = 3'd4,
    REQ_SCROLL      = 3'd5
  } req_type_e;

  // address map
  localparam logic [15:0] ADDR_SOUND_LO   = 16'h8000;
  localparam logic [15:0] ADDR_SOUND_HI   = 16'h8003;
  localparam logic [15:0] ADDR_BANK       = 16'h8006;
  localparam logic [15:0] ADDR_P1         = 16'ha000;
  localparam logic [15:0] ADDR_P2         = 16'ha001;
  localparam logic [15:0] ADDR_STATUS     = 16'ha002;
  localparam logic [15:0] ADDR_FLIP       = 16'ha003;
  localparam logic [15:0] ADDR_BG_BASE    = 16'hc800;
  localparam logic [15:0] ADDR_BG_MASK    = 16'hf800;
  localparam logic [15:0] ADDR_PAL_LO     = 16'hd800;
  localparam logic [15:0] ADDR_PAL_HI     = 16'hdaff;
  localparam logic [15:0] BG_ROW_MASK     = 16'h07e0;

  // handshake commands written to the status port
  localparam logic [7:0] HS_CMD_SET_LOW   = 8'h00;
  localparam logic [7:0] HS_CMD_40        = 8'h40;
  localparam logic [7:0] HS_CMD_80        = 8'h80;

  // status bits
  localparam logic [7:0] ST_SUB_ACK       = 8'h04;
  localparam logic [7:0] ST_MAIN_ACK      = 8'h08;
  localparam logic [7:0] ST_SUB_READY     = 8'h10;
  localparam logic [7:0] ST_MAIN_READY    = 8'h20;
  localparam logic [7:0] ST_READ_MASK     = 8'hfd;
  localparam logic [7:0] ST_NOT_VBLANK    = 8'h02;

  // one result item, before the background read data is merged
  typedef struct packed {
    logic        bg_read;
    logic [7:0]  read_value;
    logic        irq_main;
    logic        irq_sub;
    logic [2:0]  rom_bank;
    logic        flip_screen;
    logic        sound_access;
    logic        palette_strobe;
    logic [9:0]  palette_index;
    logic [23:0] palette_rgb;
  } result_t;

  function automatic logic [7:0] expand4(input logic [3:0] n);
    return {n, n};
  endfunction

  // 8-bit palette byte to 24-bit rgb, red in the high byte
  function automatic logic [23:0] decode_colour(input logic [7:0] v);
    logic [3:0] r;
    logic [3:0] g;
    logic [3:0] b;
    r = {v[3:2], v[1:0]};
    g = {v[5:4], v[1:0]};
    b = {v[7:6], v[1:0]};
    return {expand4(r), expand4(g), expand4(b)};
  endfunction

endpackage

// ===== sv/dcbg_ram.sv =====
// ----------------------------------------------------------------------------
// dcbg_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dcbg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dual_cpu_board_glue_unit.sv =====
// ----------------------------------------------------------------------------
// dual_cpu_board_glue_unit
// Bus glue shared by the main and sub CPU: background RAM, handshake status,
// vblank flag, scroll, bank and flip registers, palette byte decode.
// ----------------------------------------------------------------------------
// One bus access or board event is taken per cycle while the result path has
// room; each gives one result via the RAM read stage and output register.
// The background RAM is a single memory with one write and one registered
// read port; a write lands at the accept edge, so a read that follows in the
// next cycle already sees it. After reset the block clears the background RAM
// one entry a cycle, holding s_axis_tready low until all BG_STORE_DEPTH
// entries (2048 by default) are clear. The two-deep result path takes one
// more transfer while a result waits on m_axis_tready.
module dual_cpu_board_glue_unit
  import dcbg_pkg::*;
#(
  parameter int unsigned BG_STORE_DEPTH = BG_STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cpu_id, bus_address, write_value, player_one_port, player_two_port
  input  logic [47:0] s_axis_tdata,
  // req_type
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_value, irq_main, irq_sub, rom_bank, flip_screen, sound_access,
  // palette_index, palette_rgb
  output logic [55:0] m_axis_tdata,
  // palette_strobe
  output logic        m_axis_tuser
);

  localparam int unsigned BgAddrW = $clog2(BG_STORE_DEPTH);

  // input fields
  logic        cpu_sub;
  logic [15:0] addr;
  logic [7:0]  wval;
  logic [7:0]  p1;
  logic [7:0]  p2;
  req_type_e   req;

  assign cpu_sub = s_axis_tdata[0];
  assign addr    = s_axis_tdata[16:1];
  assign wval    = s_axis_tdata[24:17];
  assign p1      = s_axis_tdata[32:25];
  assign p2      = s_axis_tdata[40:33];
  assign req     = req_type_e'(s_axis_tuser);

  // small state
  logic [7:0] status_q, status_d;
  logic       vblank_q, vblank_d;
  logic [4:0] scroll_q, scroll_d;
  logic [2:0] bank_q, bank_d;
  logic       flip_q, flip_d;

  // clearing pass
  logic               clr_q;
  logic [BgAddrW-1:0] clr_cnt_q;

  // pipeline
  logic    s1_valid_q, o_valid_q;
  result_t s1_q, res_d;
  result_t o_q;
  logic    s1_move, accept;

  assign s1_move       = s1_valid_q && (!o_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_q && (!s1_valid_q || s1_move);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // background address, column rotated by the coarse scroll
  logic [4:0]         bg_col;
  logic [15:0]        bg_full;
  logic [BgAddrW-1:0] bg_addr;
  logic               bg_hit;

  assign bg_col  = addr[4:0] + scroll_q;
  assign bg_full = (addr & BG_ROW_MASK) | {11'd0, bg_col};
  assign bg_addr = bg_full[BgAddrW-1:0];
  assign bg_hit  = (addr & ADDR_BG_MASK) == ADDR_BG_BASE;

  logic bg_we;
  logic bg_re;

  always_comb begin
    status_d = status_q;
    vblank_d = vblank_q;
    scroll_d = scroll_q;
    bank_d   = bank_q;
    flip_d   = flip_q;
    res_d    = '0;
    bg_we    = 1'b0;
    bg_re    = 1'b0;

    if ((req == REQ_WRITE || req == REQ_READ) &&
        addr >= ADDR_SOUND_LO && addr <= ADDR_SOUND_HI) begin
      res_d.sound_access = 1'b1;
    end

    unique case (req)
      REQ_WRITE: begin
        priority if (addr >= ADDR_PAL_LO && addr <= ADDR_PAL_HI) begin
          res_d.palette_strobe = 1'b1;
          res_d.palette_index  = addr[9:0];
          res_d.palette_rgb    = decode_colour(wval);
        end else if (bg_hit) begin
          bg_we = accept;
        end else if (addr == ADDR_STATUS) begin
          if (!cpu_sub) begin
            priority if (wval == HS_CMD_SET_LOW) begin
              status_d = status_q | ST_MAIN_READY;
            end else if (wval == HS_CMD_80) begin
              status_d = status_q | ST_SUB_ACK;
            end else if (wval == HS_CMD_40) begin
              status_d      = status_q & ~ST_MAIN_ACK;
              res_d.irq_sub = 1'b1;
            end else begin
            end
          end else begin
            priority if (wval == HS_CMD_SET_LOW) begin
              status_d = status_q | ST_SUB_READY;
            end else if (wval == HS_CMD_40) begin
              status_d = status_q | ST_MAIN_ACK;
            end else if (wval == HS_CMD_80) begin
              status_d       = status_q & ~ST_SUB_ACK;
              res_d.irq_main = 1'b1;
            end else begin
            end
          end
        end else if (addr == ADDR_FLIP) begin
          flip_d = wval[0];
        end else if (addr == ADDR_BANK && cpu_sub) begin
          bank_d = wval[2:0];
        end else begin
        end
      end
      REQ_READ: begin
        priority if (bg_hit) begin
          res_d.bg_read = 1'b1;
          bg_re         = accept;
        end else if (addr == ADDR_P1) begin
          res_d.read_value = p1;
        end else if (addr == ADDR_P2) begin
          res_d.read_value = p2;
        end else if (addr == ADDR_STATUS) begin
          res_d.read_value = (status_q & ST_READ_MASK) |
                             (vblank_q ? 8'd0 : ST_NOT_VBLANK);
        end else begin
        end
      end
      REQ_FRAME_START: begin
        vblank_d       = 1'b1;
        status_d       = status_q & ~ST_MAIN_READY;
        res_d.irq_main = 1'b1;
      end
      REQ_VBLANK_END: begin
        vblank_d = 1'b0;
      end
      REQ_TIMER_TICK: begin
        status_d      = status_q & ~ST_SUB_READY;
        res_d.irq_sub = 1'b1;
      end
      REQ_SCROLL: begin
        scroll_d = wval[7:3];
      end
      default: begin
      end
    endcase

    res_d.rom_bank    = bank_d;
    res_d.flip_screen = flip_d;
  end

  // background RAM, write port shared with the clearing pass
  logic               ram_we;
  logic [BgAddrW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;

  assign ram_we    = clr_q || bg_we;
  assign ram_waddr = clr_q ? clr_cnt_q : bg_addr;
  assign ram_wdata = clr_q ? 8'd0 : wval;

  dcbg_ram #(
    .Width (8),
    .Depth (BG_STORE_DEPTH)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (bg_re),
    .raddr_i (bg_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= '0;
      vblank_q  <= 1'b0;
      scroll_q  <= '0;
      bank_q    <= '0;
      flip_q    <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == BgAddrW'(BG_STORE_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (accept) begin
        status_q <= status_d;
        vblank_q <= vblank_d;
        scroll_q <= scroll_d;
        bank_q   <= bank_d;
        flip_q   <= flip_d;
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // payload, background read data merged on the way to the output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res_d;
    end
    if (s1_move) begin
      o_q <= s1_q;
      if (s1_q.bg_read) begin
        o_q.read_value <= ram_rdata;
      end
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_q.palette_strobe;
  assign m_axis_tdata  = {7'd0, o_q.palette_rgb, o_q.palette_index, o_q.sound_access,
                          o_q.flip_screen, o_q.rom_bank, o_q.irq_sub, o_q.irq_main,
                          o_q.read_value};

endmodule

// ===== bench/dual_cpu_board_glue_unit_test.sv =====
// ----------------------------------------------------------------------------
// dual_cpu_board_glue_unit_test
// Self-checking bench for the dual CPU board glue. A queue of bus accesses
// and board events feeds a bursty stream driver; each transfer is run
// through a local model of the glue and the expected result is compared
// field by field with what comes out of the master side, which stalls on a
// pattern of its own and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module dual_cpu_board_glue_unit_test;
  import dcbg_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 20;

  // request codes the block does not decode
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic        cpu;
    logic [15:0] addr;
    logic [7:0]  wval;
    logic [7:0]  p1;
    logic [7:0]  p2;
    bit          wait_idle;   // hold this one back until all results are in
  } bus_item_t;

  typedef struct {
    logic [7:0]  read_value;
    logic        irq_main;
    logic        irq_sub;
    logic [2:0]  rom_bank;
    logic        flip_screen;
    logic        sound_access;
    logic        palette_strobe;
    logic [9:0]  palette_index;
    logic [23:0] palette_rgb;
  } glue_result_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_style_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // cpu_id, bus_address, write_value, player_one_port, player_two_port
  logic [47:0] s_axis_tdata = '0;
  // req_type
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // read_value, irq_main, irq_sub, rom_bank, flip_screen, sound_access,
  // palette_index, palette_rgb
  logic [55:0] m_axis_tdata;
  // palette_strobe
  logic        m_axis_tuser;

  dual_cpu_board_glue_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // model state of the glue
  logic [7:0] bg_mem [0:2047];
  logic [7:0] status_byte = '0;
  logic       vblank = 1'b0;
  logic [4:0] scroll = '0;
  logic [2:0] bank = '0;
  logic       flip = 1'b0;

  bus_item_t    pending_items [$];
  glue_result_t results_due [$];
  bus_item_t    cur_item;

  int unsigned items_in = 0;
  int unsigned results_checked = 0;
  int unsigned failures = 0;
  int unsigned kind_count [0:7];
  int unsigned cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [23:0] palette_colour(input logic [7:0] v);
    logic [3:0] r4;
    logic [3:0] g4;
    logic [3:0] b4;
    logic [7:0] rb;
    logic [7:0] gb;
    logic [7:0] bb;
    r4 = {v[3:2], v[1:0]};
    g4 = {v[5:4], v[1:0]};
    b4 = {v[7:6], v[1:0]};
    rb = 8'(r4) * 8'h11;
    gb = 8'(g4) * 8'h11;
    bb = 8'(b4) * 8'h11;
    return {rb, gb, bb};
  endfunction

  // one transfer through the glue: updates the model state, returns the result
  function automatic glue_result_t glue_predict(input bus_item_t it);
    glue_result_t r;
    logic [10:0]  slot;
    r = '{default: '0};
    slot = {it.addr[10:5], 5'(it.addr[4:0] + scroll)};
    if ((it.kind == REQ_WRITE || it.kind == REQ_READ) &&
        it.addr >= ADDR_SOUND_LO && it.addr <= ADDR_SOUND_HI)
      r.sound_access = 1'b1;
    case (it.kind)
      REQ_WRITE: begin
        if (it.addr >= ADDR_PAL_LO && it.addr <= ADDR_PAL_HI) begin
          r.palette_strobe = 1'b1;
          r.palette_index  = it.addr[9:0];
          r.palette_rgb    = palette_colour(it.wval);
        end else if ((it.addr & ADDR_BG_MASK) == ADDR_BG_BASE) begin
          bg_mem[slot] = it.wval;
        end else if (it.addr == ADDR_STATUS) begin
          if (!it.cpu) begin
            if (it.wval == HS_CMD_SET_LOW) status_byte |= ST_MAIN_READY;
            else if (it.wval == HS_CMD_80) status_byte |= ST_SUB_ACK;
            else if (it.wval == HS_CMD_40) begin
              status_byte &= ~ST_MAIN_ACK;
              r.irq_sub = 1'b1;
            end
          end else begin
            if (it.wval == HS_CMD_SET_LOW) status_byte |= ST_SUB_READY;
            else if (it.wval == HS_CMD_40) status_byte |= ST_MAIN_ACK;
            else if (it.wval == HS_CMD_80) begin
              status_byte &= ~ST_SUB_ACK;
              r.irq_main = 1'b1;
            end
          end
        end else if (it.addr == ADDR_FLIP) begin
          flip = it.wval[0];
        end else if (it.addr == ADDR_BANK && it.cpu) begin
          bank = it.wval[2:0];
        end
      end
      REQ_READ: begin
        if ((it.addr & ADDR_BG_MASK) == ADDR_BG_BASE) r.read_value = bg_mem[slot];
        else if (it.addr == ADDR_P1) r.read_value = it.p1;
        else if (it.addr == ADDR_P2) r.read_value = it.p2;
        else if (it.addr == ADDR_STATUS)
          r.read_value = (status_byte & ST_READ_MASK) | (vblank ? 8'h00 : ST_NOT_VBLANK);
      end
      REQ_FRAME_START: begin
        vblank = 1'b1;
        status_byte &= ~ST_MAIN_READY;
        r.irq_main = 1'b1;
      end
      REQ_VBLANK_END: vblank = 1'b0;
      REQ_TIMER_TICK: begin
        status_byte &= ~ST_SUB_READY;
        r.irq_sub = 1'b1;
      end
      REQ_SCROLL: scroll = it.wval[7:3];
      default: ;
    endcase
    r.rom_bank    = bank;
    r.flip_screen = flip;
    return r;
  endfunction

  function automatic bus_item_t mk(input logic [2:0] kind, input logic cpu,
                                   input logic [15:0] addr, input logic [7:0] wval);
    bus_item_t it;
    it.kind      = kind;
    it.cpu       = cpu;
    it.addr      = addr;
    it.wval      = wval;
    it.p1        = 8'($urandom);
    it.p2        = 8'($urandom);
    it.wait_idle = 1'b0;
    return it;
  endfunction

  // background addresses mostly fall in a few rows so reads find written data
  function automatic logic [15:0] bg_addr();
    if ($urandom_range(0, 7) == 0) return ADDR_BG_BASE | 16'($urandom_range(0, 2047));
    return ADDR_BG_BASE | 16'($urandom_range(0, 3) << 5) | 16'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] hs_value();
    case ($urandom_range(0, 3))
      0: return HS_CMD_SET_LOW;
      1: return HS_CMD_40;
      2: return HS_CMD_80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] misc_addr();
    case ($urandom_range(0, 9))
      0: return ADDR_P1;
      1: return ADDR_P2;
      2: return ADDR_STATUS;
      3: return ADDR_FLIP;
      4: return ADDR_BANK;
      5: return 16'($urandom_range(ADDR_SOUND_LO, ADDR_SOUND_HI + 3));
      6: return 16'($urandom_range(ADDR_PAL_LO - 2, ADDR_PAL_HI + 2));
      7: return ADDR_BG_BASE - 16'($urandom_range(1, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  // push one short sequence of random content; returns how many items
  function automatic int add_random_chunk();
    logic [15:0] a;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      // handshake: command then status read
      pending_items.push_back(mk(REQ_WRITE, 1'($urandom), ADDR_STATUS, hs_value()));
      pending_items.push_back(mk(REQ_READ, 1'($urandom), ADDR_STATUS, 8'($urandom)));
      return 2;
    end else if (pick < 45) begin
      // background write followed by a read, sometimes with a scroll change between
      a = bg_addr();
      pending_items.push_back(mk(REQ_WRITE, 1'($urandom), a, 8'($urandom)));
      if ($urandom_range(0, 3) == 0) begin
        pending_items.push_back(mk(REQ_SCROLL, 1'($urandom), 16'($urandom), 8'($urandom)));
        pending_items.push_back(mk(REQ_READ, 1'($urandom), bg_addr(), 8'($urandom)));
        return 3;
      end
      pending_items.push_back(mk(REQ_READ, 1'($urandom),
                                 ($urandom_range(0, 1) == 0) ? a : bg_addr(), 8'($urandom)));
      return 2;
    end else if (pick < 52) begin
      pending_items.push_back(mk(REQ_SCROLL, 1'($urandom), 16'($urandom), 8'($urandom)));
      return 1;
    end else if (pick < 64) begin
      pending_items.push_back(mk(3'($urandom_range(REQ_FRAME_START, REQ_TIMER_TICK)),
                                 1'($urandom), 16'($urandom), 8'($urandom)));
      return 1;
    end else if (pick < 74) begin
      pending_items.push_back(mk(REQ_WRITE, 1'($urandom),
                                 16'($urandom_range(ADDR_PAL_LO, ADDR_PAL_HI)), 8'($urandom)));
      return 1;
    end else if (pick < 94) begin
      pending_items.push_back(mk(3'($urandom_range(REQ_WRITE, REQ_READ)), 1'($urandom),
                                 misc_addr(), 8'($urandom)));
      return 1;
    end
    // noise: any code, any address
    pending_items.push_back(mk(3'($urandom_range(0, 7)), 1'($urandom), 16'($urandom),
                               8'($urandom)));
    return 1;
  endfunction

  task automatic load_directed();
    bus_item_t it;
    // status right after reset: not in vblank
    it = mk(REQ_READ, 1'b0, ADDR_STATUS, 8'h00);
    it.wait_idle = 1'b1;
    pending_items.push_back(it);
    pending_items.push_back(mk(REQ_WRITE, 1'b0, ADDR_BG_BASE, 8'hff));
    pending_items.push_back(mk(REQ_READ, 1'b1, ADDR_BG_BASE, 8'h00));
    // full scroll wraps column 1 onto column 0
    pending_items.push_back(mk(REQ_SCROLL, 1'b0, 16'hffff, 8'hff));
    pending_items.push_back(mk(REQ_READ, 1'b0, ADDR_BG_BASE | 16'h0001, 8'h00));
    pending_items.push_back(mk(REQ_WRITE, 1'b1, 16'hcfff, 8'ha5));
    pending_items.push_back(mk(REQ_READ, 1'b0, 16'hcfff, 8'h00));
    pending_items.push_back(mk(REQ_SCROLL, 1'b1, 16'h0000, 8'h00));
    // palette edges and just past the end
    pending_items.push_back(mk(REQ_WRITE, 1'b0, ADDR_PAL_LO, 8'h00));
    pending_items.push_back(mk(REQ_WRITE, 1'b1, ADDR_PAL_HI, 8'hff));
    pending_items.push_back(mk(REQ_WRITE, 1'b0, ADDR_PAL_HI + 16'd1, 8'h5a));
    // handshake from both sides, plus a value with no meaning
    pending_items.push_back(mk(REQ_WRITE, 1'b0, ADDR_STATUS, HS_CMD_SET_LOW));
    pending_items.push_back(mk(REQ_WRITE, 1'b0, ADDR_STATUS, HS_CMD_80));
    pending_items.push_back(mk(REQ_WRITE, 1'b1, ADDR_STATUS, HS_CMD_SET_LOW));
    pending_items.push_back(mk(REQ_WRITE, 1'b1, ADDR_STATUS, HS_CMD_40));
    pending_items.push_back(mk(REQ_WRITE, 1'b0, ADDR_STATUS, HS_CMD_40));
    pending_items.push_back(mk(REQ_WRITE, 1'b1, ADDR_STATUS, HS_CMD_80));
    pending_items.push_back(mk(REQ_WRITE, 1'b1, ADDR_STATUS, 8'h11));
    // frame start, status in vblank, vblank end, timer tick
    pending_items.push_back(mk(REQ_FRAME_START, 1'b1, 16'hffff, 8'hff));
    pending_items.push_back(mk(REQ_READ, 1'b0, ADDR_STATUS, 8'h00));
    pending_items.push_back(mk(REQ_VBLANK_END, 1'b0, 16'h0000, 8'h00));
    pending_items.push_back(mk(REQ_TIMER_TICK, 1'b0, 16'h0000, 8'h00));
    // flip, bank from sub and from main (ignored)
    pending_items.push_back(mk(REQ_WRITE, 1'b1, ADDR_FLIP, 8'h01));
    pending_items.push_back(mk(REQ_WRITE, 1'b1, ADDR_BANK, 8'hff));
    pending_items.push_back(mk(REQ_WRITE, 1'b0, ADDR_BANK, 8'h00));
    // sound range edges, ports, write to a read-only port, spare codes
    pending_items.push_back(mk(REQ_READ, 1'b0, ADDR_SOUND_LO, 8'h00));
    pending_items.push_back(mk(REQ_WRITE, 1'b1, ADDR_SOUND_HI, 8'h77));
    it = mk(REQ_READ, 1'b0, ADDR_P1, 8'h00);
    it.p1 = 8'h00;
    pending_items.push_back(it);
    it = mk(REQ_READ, 1'b1, ADDR_P2, 8'h00);
    it.p2 = 8'hff;
    pending_items.push_back(it);
    pending_items.push_back(mk(REQ_WRITE, 1'b0, ADDR_P1, 8'h3c));
    pending_items.push_back(mk(REQ_SPARE_6, 1'b1, ADDR_STATUS, HS_CMD_40));
    pending_items.push_back(mk(REQ_SPARE_7, 1'b0, ADDR_FLIP, 8'h00));
  endtask

  // stream driver: bursts of random length with random gaps
  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(glue_predict(cur_item));
        kind_count[cur_item.kind]++;
        items_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].wait_idle && results_due.size() > 0)) begin
          cur_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, cur_item.p2, cur_item.p1, cur_item.wval,
                            cur_item.addr, cur_item.cpu};
          s_axis_tuser  <= cur_item.kind;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls: a style per stretch of cycles, plus one long hold-off
  rx_style_e rx_style = RX_OPEN;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_checked >= 300) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_cycle % 48 == 0) rx_style = rx_style_e'($urandom_range(0, 3));
        case (rx_style)
          RX_OPEN:     m_axis_tready <= 1'b1;
          RX_HALF:     m_axis_tready <= 1'($urandom);
          RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: m_axis_tready <= (rx_cycle % 5 != 0);
          default:     m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin
    glue_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with nothing expected: tdata 0x%0h", m_axis_tdata);
        failures++;
      end else begin
        want = results_due.pop_front();
        check_field("read_value", want.read_value, m_axis_tdata[7:0]);
        check_field("irq_main", want.irq_main, m_axis_tdata[8]);
        check_field("irq_sub", want.irq_sub, m_axis_tdata[9]);
        check_field("rom_bank", want.rom_bank, m_axis_tdata[12:10]);
        check_field("flip_screen", want.flip_screen, m_axis_tdata[13]);
        check_field("sound_access", want.sound_access, m_axis_tdata[14]);
        check_field("palette_index", want.palette_index, m_axis_tdata[24:15]);
        check_field("palette_rgb", want.palette_rgb, m_axis_tdata[48:25]);
        check_field("palette_strobe", want.palette_strobe, m_axis_tuser);
      end
      results_checked++;
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, results_due.size());
    $display("[dual_cpu_board_glue_unit] ERROR");
    $finish;
  end

  initial begin
    int made;
    int chunks;
    bus_item_t it;
    foreach (bg_mem[i]) bg_mem[i] = '0;
    foreach (kind_count[i]) kind_count[i] = 0;
    load_directed();
    made = 0;
    chunks = 0;
    while (made < RANDOM_ITEMS) begin
      // every so often the sender waits for the output side to drain
      if (chunks % 150 == 149) begin
        it = mk(REQ_READ, 1'($urandom), ADDR_STATUS, 8'($urandom));
        it.wait_idle = 1'b1;
        pending_items.push_back(it);
        made++;
      end
      made += add_random_chunk();
      chunks++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() > 0 || s_axis_tvalid || results_due.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (results_due.size() > 0) begin
      $error("%0d expected results never arrived", results_due.size());
      failures++;
    end
    $display("%0d transfers in (write %0d, read %0d, events %0d, scroll %0d, spare codes %0d)",
             items_in, kind_count[REQ_WRITE], kind_count[REQ_READ],
             kind_count[REQ_FRAME_START] + kind_count[REQ_VBLANK_END] +
             kind_count[REQ_TIMER_TICK], kind_count[REQ_SCROLL],
             kind_count[REQ_SPARE_6] + kind_count[REQ_SPARE_7]);
    $display("%0d results checked under stalls and a %0d-cycle hold-off, %0d failures",
             results_checked, LONG_HOLD, failures);
    if (failures == 0) begin
      $display("[dual_cpu_board_glue_unit] OK");
    end else begin
      $display("[dual_cpu_board_glue_unit] ERROR");
    end
    $finish;
  end

endmodule
